>>> hw/rtl/u2l_pkg.sv
// Shared types and constants of the UTF-8 to Latin-1 stream decoder.
// Used by the front end, the item queue, the back end and the top level.
// No dependencies.
package u2l_pkg;

  // Class of one incoming byte, decided by the front end
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_TRAIL,
    KIND_BAD
  } kind_t;

  // Decoder state of the back end
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COLLECT,
    MODE_INVALID
  } mode_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  data;
    logic        last;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [7:0] ch;
    logic       sub;
    logic       last;
  } res_t;

  // Byte patterns used in classification
  localparam logic [7:0] MASK_TOP1   = 8'h80;
  localparam logic [7:0] MASK_TOP2   = 8'hC0;
  localparam logic [7:0] MASK_TOP3   = 8'hE0;
  localparam logic [7:0] MASK_TOP4   = 8'hF0;
  localparam logic [7:0] MASK_TOP5   = 8'hF8;
  localparam logic [7:0] PAT_TRAIL   = 8'h80;
  localparam logic [7:0] PAT_LEAD2   = 8'hC0;
  localparam logic [7:0] PAT_LEAD3   = 8'hE0;
  localparam logic [7:0] PAT_LEAD4   = 8'hF0;

  // Configuration
  localparam logic [7:0] REPL_RESET  = 8'h3F;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic       REG_REPL    = 1'b0;

  // Buffering
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH       = 4;
  localparam int unsigned OUT_PTR_W       = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W       = $clog2(OUT_DEPTH + 1);

endpackage

>>> hw/rtl/u2l_in_if.sv
// Input channel of the decoder: one raw UTF-8 byte per item with its string-end flag.
// Valid/ready handshake. No dependencies.
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

>>> hw/rtl/u2l_out_if.sv
// Result channel of the decoder: one Latin-1 byte per item with its flags.
// Valid/ready handshake. No dependencies.
interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       substituted;
  logic       last_out;

  modport source (output valid, output out_char, output substituted, output last_out,
                  input ready);
  modport sink   (input valid, input out_char, input substituted, input last_out,
                  output ready);
endinterface

>>> hw/rtl/utf8_to_latin1_stream_decoder_top.sv
// Top level of the UTF-8 to Latin-1 stream decoder: configuration register,
// front end, item queue and back end. Depends on u2l_pkg, u2l_in_if, u2l_out_if,
// u2l_front, u2l_queue and u2l_back.
//
// Usage: bytes of a UTF-8 string enter on in_chan, one per item, with last_in
// set on the final byte of each string. Each decoded sequence leaves on out_chan
// as one Latin-1 byte; substituted marks a replacement and last_out the final
// result of a string. A byte gives zero, one or two results.
// The replacement byte sits in the one register at byte address 0 of the APB
// port; it may only be changed while the decoder is idle.
// The byte that completes a result is registered in the queue and the result in
// the output buffer before it leaves on out_chan.
// Throughput: one byte per cycle while the output buffer has room for two results;
// the second result of a byte that yields two is absorbed by the four-entry buffer.
// Reset clears the decoder state, the queue and the output buffer and sets the
// replacement byte to '?'. When the receiver stalls, the output buffer fills,
// then the queue, and only then does in_chan.ready fall.
module utf8_to_latin1_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = u2l_pkg::QUEUE_DEPTH_DEF  // 2 to 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  u2l_in_if.sink                         in_chan,
  u2l_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [u2l_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import u2l_pkg::*;

  logic [7:0] repl_r, repl_nxt;
  logic       q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  entry_t     q_wr_data, q_rd_data;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REPL) ? {24'd0, repl_r} : 32'd0;

  always_comb begin
    repl_nxt = repl_r;
    if (psel && penable && pwrite && pready && (paddr[2] == REG_REPL)) begin
      repl_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else begin
      repl_r <= repl_nxt;
    end
  end

  // Classification
  u2l_front u_front (
    .in_chan    (in_chan),
    .q_wr_valid (q_wr_valid),
    .q_wr_data  (q_wr_data),
    .q_wr_ready (q_wr_ready)
  );

  // Decoupling queue
  u2l_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_data  (q_wr_data),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_data  (q_rd_data),
    .rd_ready (q_rd_ready)
  );

  // Decoding and output buffering
  u2l_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .repl_char  (repl_r),
    .q_rd_valid (q_rd_valid),
    .q_rd_data  (q_rd_data),
    .q_rd_ready (q_rd_ready),
    .out_chan   (out_chan)
  );

endmodule

>>> hw/rtl/u2l_front.sv
// Front end of the decoder: accepts input bytes and classifies them.
// Depends on u2l_pkg and u2l_in_if.
module u2l_front (
  u2l_in_if.sink           in_chan,
  output logic             q_wr_valid,
  output u2l_pkg::entry_t  q_wr_data,
  input  logic             q_wr_ready
);
  import u2l_pkg::*;

  logic [7:0] b;

  assign b = in_chan.in_byte;

  // Handshake passes straight to the queue
  assign q_wr_valid    = in_chan.valid;
  assign in_chan.ready = q_wr_ready;

  // Classify the byte and keep only the payload bits of its class
  always_comb begin
    q_wr_data.last = in_chan.last_in;
    if ((b & MASK_TOP1) == 8'h00) begin
      q_wr_data.kind = KIND_ASCII;
      q_wr_data.data = b[6:0];
    end else if ((b & MASK_TOP2) == PAT_TRAIL) begin
      q_wr_data.kind = KIND_TRAIL;
      q_wr_data.data = {1'b0, b[5:0]};
    end else if ((b & MASK_TOP3) == PAT_LEAD2) begin
      q_wr_data.kind = KIND_LEAD2;
      q_wr_data.data = {2'b00, b[4:0]};
    end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
      q_wr_data.kind = KIND_LEAD3;
      q_wr_data.data = {3'b000, b[3:0]};
    end else if ((b & MASK_TOP5) == PAT_LEAD4) begin
      q_wr_data.kind = KIND_LEAD4;
      q_wr_data.data = {4'b0000, b[2:0]};
    end else begin
      q_wr_data.kind = KIND_BAD;
      q_wr_data.data = 7'd0;
    end
  end

endmodule

>>> hw/rtl/u2l_queue.sv
// Short register FIFO that decouples the front end from the back end.
// Depends on u2l_pkg for the entry type.
module u2l_queue #(
  parameter int unsigned DEPTH = u2l_pkg::QUEUE_DEPTH_DEF  // 2 to 16 entries
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  u2l_pkg::entry_t  wr_data,
  output logic             wr_ready,
  output logic             rd_valid,
  output u2l_pkg::entry_t  rd_data,
  input  logic             rd_ready
);
  import u2l_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/u2l_back.sv
// Back end of the decoder: runs the UTF-8 state machine on classified items and
// buffers up to two results per item. Depends on u2l_pkg and u2l_out_if.
module u2l_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       repl_char,
  input  logic             q_rd_valid,
  input  u2l_pkg::entry_t  q_rd_data,
  output logic             q_rd_ready,
  u2l_out_if.source        out_chan
);
  import u2l_pkg::*;

  // Outcome of handling a byte as if the decoder were idle
  typedef struct packed {
    logic        emit;
    res_t        res;
    mode_t       mode;
    logic [1:0]  rem;
    logic [20:0] acc;
  } start_t;

  function automatic start_t start_byte(entry_t e, logic [7:0] rep);
    start_t s;
    s.emit = 1'b0;
    s.res  = '{ch: rep, sub: 1'b1, last: 1'b1};
    s.mode = MODE_IDLE;
    s.rem  = 2'd0;
    s.acc  = 21'd0;
    case (e.kind)
      KIND_ASCII: begin
        s.emit = 1'b1;
        s.res  = '{ch: {1'b0, e.data}, sub: 1'b0, last: e.last};
      end
      KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
        if (e.last) begin
          s.emit = 1'b1;
        end else begin
          s.mode = MODE_COLLECT;
          s.acc  = {14'd0, e.data};
          s.rem  = (e.kind == KIND_LEAD2) ? 2'd1 :
                   (e.kind == KIND_LEAD3) ? 2'd2 : 2'd3;
        end
      end
      default: begin
        // Stray trailing byte or invalid lead byte opens an invalid group, or at string end gives a replacement
        if (e.last) begin
          s.emit = 1'b1;
        end else begin
          s.mode = MODE_INVALID;
        end
      end
    endcase
    return s;
  endfunction

  mode_t               mode_r, mode_nxt;
  logic [1:0]          rem_r, rem_nxt;
  logic [20:0]         acc_r, acc_nxt;
  res_t                obuf_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] ob_wr_r, ob_wr_nxt, ob_rd_r, ob_rd_nxt;
  logic [OUT_CNT_W-1:0] ob_cnt_r, ob_cnt_nxt;
  logic                take, pop, is_trail;
  logic [1:0]          n_res;
  res_t                res0, res1;
  start_t              st;
  logic [20:0]         acc_sh;
  logic [1:0]          rem_dec;

  // An item is taken only when the output buffer has room for two results
  assign q_rd_ready = (ob_cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign take       = q_rd_valid && q_rd_ready;
  assign is_trail   = (q_rd_data.kind == KIND_TRAIL);
  assign acc_sh     = {acc_r[14:0], q_rd_data.data[5:0]};
  assign rem_dec    = rem_r - 2'd1;
  assign st         = start_byte(q_rd_data, repl_char);

  // Decoder next state and results of the item at the queue head
  always_comb begin
    mode_nxt = mode_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    n_res    = 2'd0;
    res0     = st.res;
    res1     = st.res;
    case (mode_r)
      MODE_COLLECT: begin
        if (is_trail) begin
          if (rem_dec == 2'd0) begin
            mode_nxt = MODE_IDLE;
            rem_nxt  = 2'd0;
            acc_nxt  = 21'd0;
            n_res    = 2'd1;
            if (acc_sh[20:8] == 13'd0) begin
              res0 = '{ch: acc_sh[7:0], sub: 1'b0, last: q_rd_data.last};
            end else begin
              res0 = '{ch: repl_char, sub: 1'b1, last: q_rd_data.last};
            end
          end else if (q_rd_data.last) begin
            mode_nxt = MODE_IDLE;
            rem_nxt  = 2'd0;
            acc_nxt  = 21'd0;
            n_res    = 2'd1;
            res0     = '{ch: repl_char, sub: 1'b1, last: 1'b1};
          end else begin
            rem_nxt = rem_dec;
            acc_nxt = acc_sh;
          end
        end else begin
          // Broken sequence: replacement first, then the byte as if idle
          mode_nxt = st.mode;
          rem_nxt  = st.rem;
          acc_nxt  = st.acc;
          n_res    = st.emit ? 2'd2 : 2'd1;
          res0     = '{ch: repl_char, sub: 1'b1, last: 1'b0};
        end
      end
      MODE_INVALID: begin
        if (is_trail) begin
          if (q_rd_data.last) begin
            mode_nxt = MODE_IDLE;
            n_res    = 2'd1;
            res0     = '{ch: repl_char, sub: 1'b1, last: 1'b1};
          end
        end else begin
          mode_nxt = st.mode;
          rem_nxt  = st.rem;
          acc_nxt  = st.acc;
          n_res    = st.emit ? 2'd2 : 2'd1;
          res0     = '{ch: repl_char, sub: 1'b1, last: 1'b0};
        end
      end
      default: begin
        mode_nxt = st.mode;
        rem_nxt  = st.rem;
        acc_nxt  = st.acc;
        n_res    = st.emit ? 2'd1 : 2'd0;
      end
    endcase
    if (!take) begin
      mode_nxt = mode_r;
      rem_nxt  = rem_r;
      acc_nxt  = acc_r;
      n_res    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      rem_r  <= 2'd0;
      acc_r  <= 21'd0;
    end else begin
      mode_r <= mode_nxt;
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Output buffer: up to two writes and one read per cycle
  assign pop               = out_chan.valid && out_chan.ready;
  assign out_chan.valid    = (ob_cnt_r != '0);
  assign out_chan.out_char    = obuf_r[ob_rd_r].ch;
  assign out_chan.substituted = obuf_r[ob_rd_r].sub;
  assign out_chan.last_out    = obuf_r[ob_rd_r].last;

  always_comb begin
    ob_wr_nxt  = ob_wr_r + OUT_PTR_W'(n_res);
    ob_rd_nxt  = pop ? ob_rd_r + 1'b1 : ob_rd_r;
    ob_cnt_nxt = ob_cnt_r + OUT_CNT_W'(n_res) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      ob_wr_r  <= ob_wr_nxt;
      ob_rd_r  <= ob_rd_nxt;
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      obuf_r[ob_wr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      obuf_r[ob_wr_r + 1'b1] <= res1;
    end
  end

`ifndef SYNTHESIS
  // The buffer never overfills
  a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("output buffer overflow");

  // Collecting always expects at least one more trailing byte
  a_collect_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_COLLECT) |-> (rem_r != 2'd0))
    else $error("collecting with no bytes remaining");

  // Outside a sequence the accumulator and count are clear
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_COLLECT) |-> (acc_r == 21'd0 && rem_r == 2'd0))
    else $error("stale accumulator outside a sequence");

  // A taken item that emits leaves the buffer non-empty next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (n_res != 2'd0) |=> out_chan.valid)
    else $error("result written but not shown");
`endif

endmodule
